// ===== hw/rtl/ntan_pkg.sv =====
package ntan_pkg;

    localparam int MAX_COMPONENTS = 48;
    localparam int DATA_W         = 32;
    localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
    localparam int IDX_W          = $clog2(MAX_COMPONENTS);
    localparam int SCALE_MAX      = 31;
    localparam int SCALE_W        = 5;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

endpackage

// ===== hw/rtl/ntan_load_if.sv =====
interface ntan_load_if;
    logic                                valid;
    logic                                ready;
    logic signed [ntan_pkg::DATA_W-1:0]  next_diff;
    logic signed [ntan_pkg::DATA_W-1:0]  prev_diff;
    logic signed [ntan_pkg::DATA_W-1:0]  image_energy;
    logic signed [ntan_pkg::DATA_W-1:0]  prev_energy;
    logic signed [ntan_pkg::DATA_W-1:0]  next_energy;
    logic                                final_component;

    modport source (output valid, next_diff, prev_diff, image_energy, prev_energy,
                    next_energy, final_component, input ready);
    modport sink   (input valid, next_diff, prev_diff, image_energy, prev_energy,
                    next_energy, final_component, output ready);
endinterface

// ===== hw/rtl/ntan_result_if.sv =====
interface ntan_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ntan_pkg::DATA_W-1:0]  tangent_component;
    logic                                last_of_vector;
    logic                                overflow_flag;

    modport source (output valid, tangent_component, last_of_vector, overflow_flag,
                    input ready);
    modport sink   (input valid, tangent_component, last_of_vector, overflow_flag,
                    output ready);
endinterface

// ===== hw/rtl/ntan_mul.sv =====
module ntan_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod
);
    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

// ===== hw/rtl/ntan_sqrt.sv =====
module ntan_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one result bit per cycle, bit walks down two places at a time
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[31:0];
endmodule

// ===== hw/rtl/ntan_div.sv =====
module ntan_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [30:0] quo
);
    logic [31:0] rem_reg;
    logic [30:0] lo_reg;
    logic [30:0] quo_reg;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        take;

    assign trial = {rem_reg, lo_reg[30]};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division; upper numerator half is already below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[62:31];
            lo_reg  <= num[30:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            lo_reg  <= {lo_reg[29:0], 1'b0};
            quo_reg <= {quo_reg[29:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== hw/rtl/neb_improved_tangent.sv =====
// NEB tangent for one image, streamed one coordinate component per transaction.
// load channel: next_diff/prev_diff (Q16.16) plus three energies, sampled only
//   on the first transaction of a vector; final_component closes the vector.
// result channel: one Q2.30 unit-tangent component per buffered component,
//   last_of_vector on the final one, overflow_flag on all of them when the
//   vector had more than MAX_COMPONENTS components (extras are dropped).
// cfg: cfg_we/cfg_wdata write simple_mode (1 = plain next displacement).
// A direct-tangent component is classified and then takes two squares; an
//   energy-weighted mix first takes two products through the shared multiplier.
//   load.ready is high only when the sequencer is idle.
// After the final component the sequencer picks a sum, scales it and takes the
//   bit-serial square root; each output takes a memory read, the divider (not
//   for a zero root) and the output hold. The divider sets the emission rate.
// The output register holds its transaction while result.ready is low; the
//   sequencer simply waits, nothing is lost.
// Reset (rst_n, async low) clears the count, sums, energies and mode; the
//   component buffers need no clearing.
module neb_improved_tangent (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    ntan_load_if.sink     load,
    ntan_result_if.source result
);
    localparam int MAXC = ntan_pkg::MAX_COMPONENTS;
    localparam int CW   = ntan_pkg::CNT_W;
    localparam int IW   = ntan_pkg::IDX_W;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_CLS   = 16'h0002,
        S_MULN  = 16'h0004,
        S_MULP  = 16'h0008,
        S_ADD   = 16'h0010,
        S_SQC   = 16'h0020,
        S_SQN   = 16'h0040,
        S_ACC   = 16'h0080,
        S_PICK  = 16'h0100,
        S_SCALE = 16'h0200,
        S_SQRT  = 16'h0400,
        S_READ  = 16'h0800,
        S_QSEL  = 16'h1000,
        S_DIV   = 16'h2000,
        S_OUT   = 16'h4000,
        S_WAIT  = 16'h8000
    } state_t;

    state_t state_reg;

    logic                 simple_mode_reg;
    logic signed [31:0]   e_reg, ep_reg, en_reg;
    logic signed [31:0]   n_reg, p_reg, c_reg;
    logic                 final_reg;
    logic [30:0]          wn_reg, wp_reg;
    logic signed [47:0]   t_reg;
    logic [63:0]          csum_reg, nsum_reg, s_reg;
    logic [CW-1:0]        count_reg, idx_reg;
    logic                 dropped_reg;
    logic                 use_next_reg;
    logic [ntan_pkg::SCALE_W-1:0] m_reg;
    logic [31:0]          r_reg;
    logic                 neg_reg;
    logic signed [31:0]   tc_reg;
    logic                 last_reg;

    // component buffers
    logic signed [31:0]   comb_mem [MAXC];
    logic signed [31:0]   next_mem [MAXC];
    logic signed [31:0]   rd_c_reg, rd_n_reg;

    // shared units
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   prod;
    logic                 sqrt_start, sqrt_done;
    logic [31:0]          sqrt_root;
    logic                 div_start, div_done;
    logic [62:0]          div_num;
    logic [30:0]          div_quo;

    ntan_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ntan_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    ntan_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (r_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // energy classification and weights
    logic signed [32:0] dp, dn;
    logic [32:0]        ap_raw, an_raw;
    logic [30:0]        ap, an, lo_w, hi_w;
    logic               rise, fall;

    assign dp     = {ep_reg[31], ep_reg} - {e_reg[31], e_reg};
    assign dn     = {en_reg[31], en_reg} - {e_reg[31], e_reg};
    assign ap_raw = dp[32] ? 33'(-dp) : 33'(dp);
    assign an_raw = dn[32] ? 33'(-dn) : 33'(dn);
    assign ap     = (ap_raw > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ap_raw[30:0];
    assign an     = (an_raw > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : an_raw[30:0];
    assign lo_w   = (ap < an) ? ap : an;
    assign hi_w   = (ap < an) ? an : ap;
    assign rise   = (en_reg > e_reg) && (e_reg > ep_reg);
    assign fall   = (e_reg > en_reg) && (ep_reg > e_reg);

    // Q32.32 product rounded to Q16.16 (half up)
    logic signed [47:0] prod_rnd;
    logic signed [48:0] mix_sum;
    logic signed [31:0] mix_sat;

    assign prod_rnd = 48'((prod + 64'sd32768) >>> 16);
    assign mix_sum  = {t_reg[47], t_reg} + {prod_rnd[47], prod_rnd};
    assign mix_sat  = (mix_sum > 49'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (mix_sum < -49'sh0_8000_0000) ? 32'sh8000_0000 : mix_sum[31:0];

    // saturating accumulate of a square
    logic [64:0] csum_add, nsum_add;
    assign csum_add = {1'b0, csum_reg} + {1'b0, prod};
    assign nsum_add = {1'b0, nsum_reg} + {1'b0, prod};

    // divider operand: |c| * 2^m, capped at the root
    logic signed [31:0] sel_c;
    logic [31:0]        mag;
    logic [62:0]        mag_sh;
    logic [31:0]        q_val;

    assign sel_c  = use_next_reg ? rd_n_reg : rd_c_reg;
    assign mag    = sel_c[31] ? 32'(-sel_c) : 32'(sel_c);
    assign mag_sh = {31'b0, mag} << m_reg;
    assign q_val  = (mag_sh > {31'b0, r_reg}) ? r_reg : mag_sh[31:0];
    assign div_num = {1'b0, q_val, 30'b0} + {32'b0, r_reg[31:1]};

    logic [30:0] res_clamp;
    assign res_clamp = (div_quo > ntan_pkg::ONE_Q30) ? ntan_pkg::ONE_Q30 : div_quo;

    logic cnt_full;
    assign cnt_full = (count_reg == CW'(MAXC));

    always_comb
    begin
        mul_a = n_reg;
        mul_b = n_reg;
        case (state_reg)
            S_MULN:
            begin
                mul_a = n_reg;
                mul_b = {1'b0, wn_reg};
            end
            S_MULP:
            begin
                mul_a = p_reg;
                mul_b = {1'b0, wp_reg};
            end
            S_SQC:
            begin
                mul_a = c_reg;
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = n_reg;
                mul_b = n_reg;
            end
        endcase
    end

    assign sqrt_start = (state_reg == S_SCALE) &&
                        !((m_reg < ntan_pkg::SCALE_W'(ntan_pkg::SCALE_MAX)) &&
                          (s_reg[63:62] == 2'b00));
    assign div_start  = (state_reg == S_QSEL) && (r_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            simple_mode_reg <= 1'b0;
            e_reg           <= '0;
            ep_reg          <= '0;
            en_reg          <= '0;
            csum_reg        <= '0;
            nsum_reg        <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                simple_mode_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (load.valid)
                    begin
                        if (count_reg == '0)
                        begin
                            e_reg  <= load.image_energy;
                            ep_reg <= load.prev_energy;
                            en_reg <= load.next_energy;
                        end
                        state_reg <= S_CLS;
                    end
                end
                S_CLS:
                begin
                    if (cnt_full)
                    begin
                        dropped_reg <= 1'b1;
                        state_reg   <= final_reg ? S_PICK : S_IDLE;
                    end
                    else if (simple_mode_reg || rise || fall)
                    begin
                        state_reg <= S_SQC;
                    end
                    else
                    begin
                        state_reg <= S_MULN;
                    end
                end
                S_MULN:  state_reg <= S_MULP;
                S_MULP:  state_reg <= S_ADD;
                S_ADD:   state_reg <= S_SQC;
                S_SQC:   state_reg <= S_SQN;
                S_SQN:
                begin
                    csum_reg  <= csum_add[64] ? '1 : csum_add[63:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    nsum_reg  <= nsum_add[64] ? '1 : nsum_add[63:0];
                    count_reg <= count_reg + CW'(1);
                    state_reg <= final_reg ? S_PICK : S_IDLE;
                end
                S_PICK:  state_reg <= S_SCALE;
                S_SCALE:
                begin
                    if (sqrt_start)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:  state_reg <= S_QSEL;
                S_QSEL:  state_reg <= (r_reg == '0) ? S_OUT : S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (result.ready)
                    begin
                        if (last_reg)
                        begin
                            count_reg   <= '0;
                            csum_reg    <= '0;
                            nsum_reg    <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_WAIT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_WAIT:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg     <= load.next_diff;
                p_reg     <= load.prev_diff;
                final_reg <= load.final_component;
            end
            S_CLS:
            begin
                c_reg  <= (simple_mode_reg || rise) ? n_reg : p_reg;
                wn_reg <= (dp > dn) ? lo_w : hi_w;
                wp_reg <= (dp > dn) ? hi_w : lo_w;
            end
            S_MULP:  t_reg <= prod_rnd;
            S_ADD:   c_reg <= mix_sat;
            S_PICK:
            begin
                use_next_reg <= (csum_reg == '0);
                s_reg        <= (csum_reg == '0) ? nsum_reg : csum_reg;
                m_reg        <= '0;
            end
            S_SCALE:
            begin
                if (!sqrt_start)
                begin
                    s_reg <= {s_reg[61:0], 2'b00};
                    m_reg <= m_reg + ntan_pkg::SCALE_W'(1);
                end
            end
            S_SQRT:  r_reg <= sqrt_root;
            S_QSEL:
            begin
                neg_reg  <= sel_c[31];
                tc_reg   <= '0;
                last_reg <= (idx_reg + CW'(1) == count_reg);
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tc_reg <= neg_reg ? -$signed({1'b0, res_clamp}) : $signed({1'b0, res_clamp});
                end
            end
            default:
            begin
            end
        endcase
    end

    // buffer write on component commit, registered read for emission
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC)
        begin
            comb_mem[count_reg[IW-1:0]] <= c_reg;
            next_mem[count_reg[IW-1:0]] <= n_reg;
        end
        rd_c_reg <= comb_mem[idx_reg[IW-1:0]];
        rd_n_reg <= next_mem[idx_reg[IW-1:0]];
    end

    assign load.ready               = (state_reg == S_IDLE);
    assign result.valid             = (state_reg == S_OUT);
    assign result.tangent_component = tc_reg;
    assign result.last_of_vector    = last_reg;
    assign result.overflow_flag     = dropped_reg;

    // never loading and emitting at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(load.ready && result.valid))
        else $error("load and emit overlap");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAXC))
        else $error("component count beyond buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.tangent_component <= 32'sh4000_0000 &&
                          result.tangent_component >= -32'sh4000_0000))
        else $error("tangent component outside unit range");

    // closing transaction of a vector returns the block to load
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_of_vector) |=> ##1 load.ready)
        else $error("block not ready after vector end");
endmodule

// ===== dv/ntan_tb_if.sv =====
`timescale 1ns / 1ps

// Interfaces of the block are in the RTL tree; this file only carries the
// testbench-side transaction types used by the top.
package ntan_tb_pkg;

    typedef struct packed {
        logic signed [31:0] next_diff;
        logic signed [31:0] prev_diff;
        logic signed [31:0] image_energy;
        logic signed [31:0] prev_energy;
        logic signed [31:0] next_energy;
        logic               final_component;
    } load_item_t;

    typedef struct packed {
        logic signed [31:0] tangent_component;
        logic               last_of_vector;
        logic               overflow_flag;
    } tangent_out_t;

endpackage

// ===== dv/neb_improved_tangent_tb.sv =====
`timescale 1ns / 1ps

module neb_improved_tangent_tb;
    localparam int MAXC = ntan_pkg::MAX_COMPONENTS;

    // directed row: stimulus plus an optional typed-in result for
    // single-component vectors
    typedef struct packed {
        ntan_tb_pkg::load_item_t    it;
        logic                       chk;
        ntan_tb_pkg::tangent_out_t  exp_o;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    ntan_load_if   load ();
    ntan_result_if result ();

    neb_improved_tangent uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .load     (load.sink),
        .result   (result.source)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's buffers, sums and latches.
    // ------------------------------------------------------------------
    logic signed [31:0] comb_buf [MAXC];
    logic signed [31:0] next_buf [MAXC];
    logic [63:0]        comb_sq_sum;
    logic [63:0]        next_sq_sum;
    logic signed [31:0] e_img, e_prev, e_next;
    int                 comp_cnt;
    bit                 dropped;
    bit                 mode_simple;

    ntan_tb_pkg::tangent_out_t expected_tangents [$];
    int                        mismatches;

    // Q32.32 to Q16.16, half up; >>> is arithmetic
    function automatic longint round_q16(longint p);
        longint t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint abs_clip(longint d);
        longint a;
        a = d < 0 ? -d : d;
        return a > 64'sh7FFFFFFF ? 64'sh7FFFFFFF : a;
    endfunction

    function automatic logic [63:0] sum_clip(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] sq64(logic signed [31:0] c);
        longint v;
        v = c;
        return v * v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit-vector component in Q2.30
    function automatic logic signed [31:0] unit_component(logic signed [31:0] c,
                                                          logic [63:0] s);
        int          m;
        logic [63:0] r, mag, q;
        logic [95:0] num, res;
        m = 0;
        while (m < 31 && s[63:62] == 2'b00)
        begin
            s = s << 2;
            m++;
        end
        r = int_sqrt(s);
        if (r == 0) return 0;
        mag = c < 0 ? 64'(-longint'(c)) : 64'(c);
        q = mag << m;
        if (q > r) q = r;
        num = ({32'b0, q} << 30) + {32'b0, r >> 1};
        res = num / {32'b0, r};
        if (res > (96'd1 << 30)) res = 96'd1 << 30;
        return c < 0 ? -res[31:0] : res[31:0];
    endfunction

    function automatic logic signed [31:0] tangent_mix(logic signed [31:0] n,
                                                       logic signed [31:0] p);
        longint e, ep, en, dp, dn, ap, an, lo, hi;
        e = e_img; ep = e_prev; en = e_next;
        if (mode_simple) return n;
        if (en > e && e > ep) return n;
        if (e > en && ep > e) return p;
        dp = ep - e;
        dn = en - e;
        ap = abs_clip(dp);
        an = abs_clip(dn);
        lo = ap < an ? ap : an;
        hi = ap < an ? an : ap;
        if (dp > dn)
            return clip32(round_q16(longint'(n) * lo) + round_q16(longint'(p) * hi));
        return clip32(round_q16(longint'(n) * hi) + round_q16(longint'(p) * lo));
    endfunction

    // advance the predictor by one accepted load transaction
    task automatic predict_tangent(ntan_tb_pkg::load_item_t it);
        logic signed [31:0]        c;
        logic [63:0]               s;
        bit                        use_next;
        ntan_tb_pkg::tangent_out_t o;
        if (comp_cnt == 0)
        begin
            e_img  = it.image_energy;
            e_prev = it.prev_energy;
            e_next = it.next_energy;
        end
        if (comp_cnt < MAXC)
        begin
            c = tangent_mix(it.next_diff, it.prev_diff);
            comb_buf[comp_cnt] = c;
            next_buf[comp_cnt] = it.next_diff;
            comb_sq_sum = sum_clip(comb_sq_sum, sq64(c));
            next_sq_sum = sum_clip(next_sq_sum, sq64(it.next_diff));
            comp_cnt++;
        end
        else dropped = 1'b1;
        if (!it.final_component) return;
        // zero combined norm falls back to the next displacement
        use_next = (comb_sq_sum == 0);
        s = use_next ? next_sq_sum : comb_sq_sum;
        for (int i = 0; i < comp_cnt; i++)
        begin
            o.tangent_component = unit_component(use_next ? next_buf[i] : comb_buf[i], s);
            o.last_of_vector = (i + 1 == comp_cnt);
            o.overflow_flag = dropped;
            expected_tangents.push_back(o);
        end
        comp_cnt = 0;
        comb_sq_sum = 0;
        next_sq_sum = 0;
        dropped = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, compare each transaction.
    // ------------------------------------------------------------------
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 9) < 7) result.ready <= 1'b1;
            else if ($urandom_range(0, 9) == 0) result.ready <= 1'b0;
            else result.ready <= ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge clk)
    begin
        ntan_tb_pkg::tangent_out_t got, exp_o;
        if (rst_n && result.valid && result.ready)
        begin
            got.tangent_component = result.tangent_component;
            got.last_of_vector    = result.last_of_vector;
            got.overflow_flag     = result.overflow_flag;
            if (expected_tangents.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %h %b %b", got.tangent_component,
                             got.last_of_vector, got.overflow_flag);
            end
            else
            begin
                exp_o = expected_tangents.pop_front();
                if (got !== exp_o)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                 exp_o.tangent_component, exp_o.last_of_vector,
                                 exp_o.overflow_flag, got.tangent_component,
                                 got.last_of_vector, got.overflow_flag);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Load side
    // ------------------------------------------------------------------
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    // chk replaces the predicted single result with a typed-in one
    task automatic send_component(ntan_tb_pkg::load_item_t it, bit chk,
                                  ntan_tb_pkg::tangent_out_t exp_o);
        load.valid           <= 1'b1;
        load.next_diff       <= it.next_diff;
        load.prev_diff       <= it.prev_diff;
        load.image_energy    <= it.image_energy;
        load.prev_energy     <= it.prev_energy;
        load.next_energy     <= it.next_energy;
        load.final_component <= it.final_component;
        do @(posedge clk); while (!load.ready);
        predict_tangent(it);
        if (chk)
            expected_tangents[expected_tangents.size() - 1] = exp_o;
        load.valid <= 1'b0;
        idle_gap();
    endtask

    // wait until the block has drained, then write the mode register
    task automatic write_mode(bit m);
        while (expected_tangents.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_simple = m;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $urandom();
        endcase
    endfunction

    function automatic ntan_tb_pkg::load_item_t rand_item(bit fin);
        ntan_tb_pkg::load_item_t it;
        it.next_diff       = rand_word();
        it.prev_diff       = rand_word();
        it.image_energy    = rand_word();
        it.prev_energy     = ($urandom_range(0, 4) == 0) ? it.image_energy : rand_word();
        it.next_energy     = ($urandom_range(0, 4) == 0) ? it.prev_energy : rand_word();
        it.final_component = fin;
        return it;
    endfunction

    // directed table: {{next, prev, E, Eprev, Enext, final}, chk, {tangent, last, ovf}}
    directed_row_t directed [] = '{
        // simple-mode style vector with extremes
        '{'{32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 1'b0}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 1'b1}, 1'b0, '0},
        // energy rising: next displacement
        '{'{32'sh00010000, 32'sh00030000, 32'sh00010000, 0, 32'sh00020000, 1'b0},
          1'b0, '0},
        '{'{32'sh00020000, 32'sh00040000, 0, 0, 0, 1'b1}, 1'b0, '0},
        // energy falling: previous displacement, a single positive unit component
        '{'{32'sh00010000, 32'sh00030000, 32'sh00010000, 32'sh00020000, 0, 1'b1},
          1'b1, '{32'sh40000000, 1'b1, 1'b0}},
        // maximum: weighted mix, energy extremes saturate the weights
        '{'{32'sh00010000, 32'shFFFF0000, 32'sh7FFFFFFF, 32'sh80000000,
            32'sh80000000, 1'b0}, 1'b0, '0},
        '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 1'b1}, 1'b0, '0},
        // equal energies: zero weights, combined norm zero -> next used
        '{'{32'sh00050000, 32'sh00070000, 32'sh00010000, 32'sh00010000,
            32'sh00010000, 1'b0}, 1'b0, '0},
        '{'{32'shFFFB0000, 32'sh00000001, 0, 0, 0, 1'b1}, 1'b0, '0},
        // both norms zero
        '{'{0, 32'sh12345678, 32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0},
          1'b0, '0},
        '{'{0, 32'sh00000001, 0, 0, 0, 1'b1}, 1'b0, '0},
        // single tiny component normalizes to one
        '{'{32'sh00000001, 0, 0, 32'sh00010000, 32'sh00020000, 1'b1},
          1'b1, '{32'sh40000000, 1'b1, 1'b0}}
    };

    initial
    begin
        int len;
        mismatches  = 0;
        comp_cnt    = 0;
        comb_sq_sum = 0;
        next_sq_sum = 0;
        dropped     = 0;
        mode_simple = 0;
        e_img = 0; e_prev = 0; e_next = 0;
        load.valid <= 1'b0;
        load.next_diff <= 0;
        load.prev_diff <= 0;
        load.image_energy <= 0;
        load.prev_energy <= 0;
        load.next_energy <= 0;
        load.final_component <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // improved mode first, then simple mode on the same table
        foreach (directed[i])
            send_component(directed[i].it, directed[i].chk, directed[i].exp_o);
        write_mode(1'b1);
        foreach (directed[i])
            send_component(directed[i].it, directed[i].chk, directed[i].exp_o);
        write_mode(1'b0);

        // buffer overflow: one vector past the buffer depth
        for (int i = 0; i < MAXC + 3; i++)
            send_component(rand_item(i == MAXC + 2), 1'b0, '0);

        // random vectors, mostly short; mode switched between phases
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int v = 0; v < 7; v++)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48)
                                                   : $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    send_component(rand_item(k == len - 1), 1'b0, '0);
                // hold off until the result queue drains
                if (v == 5)
                    while (expected_tangents.size() != 0) @(posedge clk);
            end
            write_mode(ph % 2 == 0);
        end

        while (expected_tangents.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
